/* src/lpht_pkg.sv */
// Shared types and constants for the linear probing hash table.
// No dependencies; the files that use it refer to it by scoped names.
`timescale 1ns / 1ps

package lpht_pkg;

	localparam int KEY_IN_BITS   = 32;
	localparam int DIGIT_BITS    = 4;
	localparam int MOD_STEPS     = KEY_IN_BITS / DIGIT_BITS;
	localparam int STEP_W        = $clog2(MOD_STEPS);
	localparam int SLOT_OUT_BITS = 4;
	localparam int STATUS_BITS   = 2;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_SEARCH = 1'b1
	} cmd_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_INSERTED  = 2'd0,
		ST_FULL      = 2'd1,
		ST_FOUND     = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef struct packed {
		status_t                  status;
		logic [SLOT_OUT_BITS-1:0] slot;
	} result_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_MOD,
		F_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		B_CLEAR,
		B_IDLE,
		B_PROBE
	} back_state_t;

endpackage

/* src/linear_probe_hash_table.sv */
// Top level of the linear probing hash table: front end, queue, probe engine.
// Depends on lpht_pkg, lpht_front, lpht_queue, lpht_back.
`timescale 1ns / 1ps

// Usage:
// s_* carries command items: tuser[0] is the command (insert or search),
// tdata is the 32-bit key. m_* returns exactly one result item per command:
// tuser is the status, tdata[3:0] the slot.
// The front end takes an item, then works out key mod SLOTS (four key
// bits per cycle) and hands it to a two-entry queue; it takes a new item
// only after the last one is pushed. The probe engine reads one slot per
// cycle from the slot RAM, with the read data registered behind its read
// address, and walks from the home slot until it can decide the result.
// Sustained rate is set by the slower of the front end and the probe walk.
// After reset the engine clears the occupied flag of every slot, one slot
// per cycle; items are still accepted into the front end and queue.
// When m_tready is low the result holds in its output register; the
// engine waits for it to drain while the front end and queue keep filling.

module linear_probe_hash_table #(
	parameter int SLOTS    = 16,
	parameter int KEY_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] key
	input  logic [0:0]  s_tuser,   // [0] command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [3:0] slot, [7:4] zero
	output logic [1:0]  m_tuser    // [1:0] status
);

	localparam int AW = $clog2(SLOTS);
	localparam int QW = 1 + KEY_BITS + AW;

	logic                push_valid, push_ready;
	lpht_pkg::cmd_t      push_cmd, q_cmd;
	logic [KEY_BITS-1:0] push_key, q_key;
	logic [AW-1:0]       push_home, q_home;
	logic                q_valid, q_ready;
	logic [QW-1:0]       q_out;
	lpht_pkg::result_t   res;

	lpht_front #(
		.SLOTS   (SLOTS),
		.KEY_BITS(KEY_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_cmd    (lpht_pkg::cmd_t'(s_tuser[0])),
		.in_key    (s_tdata),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_cmd  (push_cmd),
		.push_key  (push_key),
		.push_home (push_home)
	);

	lpht_queue #(
		.WIDTH(QW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (push_valid),
		.in_ready (push_ready),
		.in_data  ({push_cmd, push_key, push_home}),
		.out_valid(q_valid),
		.out_ready(q_ready),
		.out_data (q_out)
	);

	assign q_cmd  = lpht_pkg::cmd_t'(q_out[QW-1]);
	assign q_key  = q_out[AW +: KEY_BITS];
	assign q_home = q_out[AW-1:0];

	lpht_back #(
		.SLOTS   (SLOTS),
		.KEY_BITS(KEY_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_cmd    (q_cmd),
		.q_key    (q_key),
		.q_home   (q_home),
		.res_valid(m_tvalid),
		.res_ready(m_tready),
		.res      (res)
	);

	assign m_tuser = res.status;
	assign m_tdata = {4'b0000, res.slot};

endmodule

/* src/lpht_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lpht_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* src/lpht_front.sv */
// Front end: accepts command items and computes the home slot, key mod SLOTS,
// four key bits per cycle. Depends on lpht_pkg.
`timescale 1ns / 1ps

module lpht_front #(
	parameter int SLOTS    = 16,
	parameter int KEY_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  lpht_pkg::cmd_t                      in_cmd,
	input  logic [lpht_pkg::KEY_IN_BITS-1:0]    in_key,
	output logic                                push_valid,
	input  logic                                push_ready,
	output lpht_pkg::cmd_t                      push_cmd,
	output logic [KEY_BITS-1:0]                 push_key,
	output logic [$clog2(SLOTS)-1:0]            push_home
);

	localparam int AW  = $clog2(SLOTS);
	localparam int RW  = AW + 1;
	localparam int KIN = lpht_pkg::KEY_IN_BITS;

	lpht_pkg::front_state_t    state_q, state_d;
	logic [KIN-1:0]            sh_q;
	logic [KEY_BITS-1:0]       key_q;
	lpht_pkg::cmd_t            cmd_q;
	logic [RW-1:0]             rem_q, rem_d;
	logic [lpht_pkg::STEP_W-1:0] cnt_q;
	logic                      accept;

	always_comb begin
		rem_d = rem_q;
		for (int i = 0; i < lpht_pkg::DIGIT_BITS; i++) begin
			rem_d = {rem_d[AW-1:0], sh_q[KIN-1-i]};
			if (rem_d >= RW'(SLOTS)) begin
				rem_d = rem_d - RW'(SLOTS);
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		push_valid = 1'b0;
		case (state_q)
			lpht_pkg::F_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = lpht_pkg::F_MOD;
				end
			end
			lpht_pkg::F_MOD: begin
				if (cnt_q == lpht_pkg::STEP_W'(lpht_pkg::MOD_STEPS - 1)) begin
					state_d = lpht_pkg::F_PUSH;
				end
			end
			lpht_pkg::F_PUSH: begin
				push_valid = 1'b1;
				if (push_ready) begin
					state_d = lpht_pkg::F_IDLE;
				end
			end
			default: state_d = lpht_pkg::F_IDLE;
		endcase
	end

	assign accept = in_ready && in_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lpht_pkg::F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// key bits above KEY_BITS are dropped before the modulo
	always_ff @(posedge clk) begin
		if (accept) begin
			sh_q  <= KIN'(KEY_BITS'(in_key));
			key_q <= KEY_BITS'(in_key);
			cmd_q <= in_cmd;
			rem_q <= '0;
			cnt_q <= '0;
		end else if (state_q == lpht_pkg::F_MOD) begin
			sh_q  <= sh_q << lpht_pkg::DIGIT_BITS;
			rem_q <= rem_d;
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign push_cmd  = cmd_q;
	assign push_key  = key_q;
	assign push_home = rem_q[AW-1:0];

endmodule

/* src/lpht_queue.sv */
// Two-entry queue between the front end and the probe engine.
// No dependencies.
`timescale 1ns / 1ps

module lpht_queue #(
	parameter int WIDTH = 38
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH-1:0] in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_data
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wp_q, rp_q;
	logic [1:0]       cnt_q;
	logic             push, pop;

	assign in_ready  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = mem_q[rp_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= in_data;
		end
	end

endmodule

/* src/lpht_back.sv */
// Probe engine: clears the slot RAM after reset, then walks slots one per
// cycle from the home slot. Depends on lpht_pkg and lpht_ram.
`timescale 1ns / 1ps

module lpht_back #(
	parameter int SLOTS    = 16,
	parameter int KEY_BITS = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     q_valid,
	output logic                     q_ready,
	input  lpht_pkg::cmd_t           q_cmd,
	input  logic [KEY_BITS-1:0]      q_key,
	input  logic [$clog2(SLOTS)-1:0] q_home,
	output logic                     res_valid,
	input  logic                     res_ready,
	output lpht_pkg::result_t        res
);

	localparam int AW = $clog2(SLOTS);
	localparam int RAM_W = KEY_BITS + 1;
	localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

	lpht_pkg::back_state_t state_q, state_d;
	logic [AW-1:0]         clr_q, ra_q, da_q, ex_q;
	logic                  rv_q;
	lpht_pkg::cmd_t        cmd_q;
	logic [KEY_BITS-1:0]   key_q;
	logic                  out_valid_q;
	lpht_pkg::result_t     out_q, res_d;

	logic                  we;
	logic [AW-1:0]         waddr;
	logic [RAM_W-1:0]      wdata, rdata;
	logic                  rd_used, rd_match, last, decide;

	lpht_ram #(
		.WIDTH(RAM_W),
		.DEPTH(SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(ra_q),
		.rdata(rdata)
	);

	assign rd_used  = rdata[KEY_BITS];
	assign rd_match = (rdata[KEY_BITS-1:0] == key_q);
	assign last     = (ex_q == LAST);

	always_comb begin
		state_d = state_q;
		q_ready = 1'b0;
		we      = 1'b0;
		waddr   = clr_q;
		wdata   = '0;
		decide  = 1'b0;
		res_d   = '{status: lpht_pkg::ST_NOT_FOUND, slot: '0};
		case (state_q)
			lpht_pkg::B_CLEAR: begin
				we = 1'b1;
				if (clr_q == LAST) begin
					state_d = lpht_pkg::B_IDLE;
				end
			end
			lpht_pkg::B_IDLE: begin
				// a result leaving this cycle frees the output register
				q_ready = !out_valid_q || res_ready;
				if (q_valid && q_ready) begin
					state_d = lpht_pkg::B_PROBE;
				end
			end
			lpht_pkg::B_PROBE: begin
				if (rv_q) begin
					if (cmd_q == lpht_pkg::CMD_INSERT) begin
						if (!rd_used) begin
							decide = 1'b1;
							we     = 1'b1;
							waddr  = da_q;
							wdata  = {1'b1, key_q};
							res_d  = '{status: lpht_pkg::ST_INSERTED,
								slot: lpht_pkg::SLOT_OUT_BITS'(da_q)};
						end else if (last) begin
							decide = 1'b1;
							res_d  = '{status: lpht_pkg::ST_FULL, slot: '0};
						end
					end else begin
						if (rd_used && rd_match) begin
							decide = 1'b1;
							res_d  = '{status: lpht_pkg::ST_FOUND,
								slot: lpht_pkg::SLOT_OUT_BITS'(da_q)};
						end else if (!rd_used || last) begin
							decide = 1'b1;
						end
					end
				end
				if (decide) begin
					state_d = lpht_pkg::B_IDLE;
				end
			end
			default: state_d = lpht_pkg::B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lpht_pkg::B_CLEAR;
			clr_q       <= '0;
			rv_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == lpht_pkg::B_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			rv_q <= (state_q == lpht_pkg::B_PROBE) && !decide;
			if (decide) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// reads run one slot ahead of the compare
	always_ff @(posedge clk) begin
		if (q_ready && q_valid) begin
			cmd_q <= q_cmd;
			key_q <= q_key;
			ra_q  <= q_home;
			ex_q  <= '0;
		end else if (state_q == lpht_pkg::B_PROBE) begin
			ra_q <= (ra_q == LAST) ? '0 : ra_q + 1'b1;
			da_q <= ra_q;
			if (rv_q) begin
				ex_q <= ex_q + 1'b1;
			end
		end
		if (decide) begin
			out_q <= res_d;
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

endmodule

/* src/lpht_checker.sv */
// Port-level assertions for linear_probe_hash_table, attached by bind.
// Depends on lpht_pkg.
`timescale 1ns / 1ps

module lpht_checker #(
	parameter int SLOTS = 16
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [7:0]  m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tvalid,
	input logic        m_tready
);

	logic [3:0] pend_q;
	logic       in_acc, out_acc;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {3'b000, in_acc} - {3'b000, out_acc};
		end
	end

	a_no_orphan_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> pend_q != 4'd0)
		else $error("result item with no command outstanding");

	a_miss_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == lpht_pkg::ST_FULL || m_tuser == lpht_pkg::ST_NOT_FOUND)
		|-> m_tdata[3:0] == 4'd0)
		else $error("full or not-found result with nonzero slot");

	a_hit_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (SLOTS < 16)
		&& (m_tuser == lpht_pkg::ST_INSERTED || m_tuser == lpht_pkg::ST_FOUND)
		|-> m_tdata[3:0] < 4'(SLOTS))
		else $error("slot outside the table");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

endmodule

bind linear_probe_hash_table lpht_checker #(
	.SLOTS(SLOTS)
) u_lpht_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready)
);

/* bench/tb_linear_probe_hash_table.sv */
// Self-checking bench for linear_probe_hash_table: insert and search items,
// results checked in order against an in-bench model of the slot table.
// Depends on lpht_pkg and the RTL under src.
`timescale 1ns / 1ps

module tb_linear_probe_hash_table;

	localparam int SLOTS          = 16;
	localparam int KEY_BITS       = 32;
	localparam int RANDOM_ITEMS   = 1930;
	localparam int SLOW_FILL_ITEMS = 1000;
	localparam int IDLE_PCT       = 14;
	localparam int QUIET_FROM     = 12000;
	localparam int QUIET_TO       = 18000;
	localparam int HOLD_AT        = 400;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 60;
	localparam int MAX_REPORTS    = 10;

	typedef struct packed {
		lpht_pkg::cmd_t cmd;
		logic [31:0]    key;
	} cmd_item_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;   // [31:0] key
	logic [0:0]  s_tuser  = '0;   // [0] command
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;         // [3:0] slot, [7:4] zero
	logic [1:0]  m_tuser;         // [1:0] status

	cmd_item_t            cmd_queue[$];
	lpht_pkg::result_t    expected_results[$];
	logic [31:0]          placed_keys[$];
	logic [KEY_BITS-1:0]  slot_key_mem [SLOTS];
	logic                 slot_taken [SLOTS];
	cmd_item_t            next_item;
	lpht_pkg::result_t    want;
	bit                   offer_taken = 1'b0;
	bit                   hold_done   = 1'b0;
	int unsigned          cycle_count  = 0;
	int unsigned          quiet_cycles = 0;
	int unsigned          results_seen = 0;
	int unsigned          hold_left    = 0;
	int unsigned          errors       = 0;
	logic                 quiet;

	assign quiet = (cycle_count >= QUIET_FROM) && (cycle_count < QUIET_TO);

	linear_probe_hash_table #(
		.SLOTS    (SLOTS),
		.KEY_BITS (KEY_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Updates the slot table the way the block does and returns its answer.
	function automatic lpht_pkg::result_t place_or_find(lpht_pkg::cmd_t cmd, logic [31:0] key_in);
		lpht_pkg::result_t   r;
		logic [KEY_BITS-1:0] key;
		int                  s;
		key = key_in[KEY_BITS-1:0];
		s = int'(key % SLOTS);
		r.slot = '0;
		if (cmd == lpht_pkg::CMD_INSERT) begin
			r.status = lpht_pkg::ST_FULL;
			for (int n = 0; n < SLOTS; n++) begin
				if (!slot_taken[s]) begin
					slot_key_mem[s] = key;
					slot_taken[s] = 1'b1;
					r.status = lpht_pkg::ST_INSERTED;
					r.slot = s[3:0];
					return r;
				end
				s = (s + 1) % SLOTS;
			end
			return r;
		end
		r.status = lpht_pkg::ST_NOT_FOUND;
		for (int n = 0; n < SLOTS; n++) begin
			if (!slot_taken[s])
				return r;
			if (slot_key_mem[s] == key) begin
				r.status = lpht_pkg::ST_FOUND;
				r.slot = s[3:0];
				return r;
			end
			s = (s + 1) % SLOTS;
		end
		return r;
	endfunction

	task automatic add_item(lpht_pkg::cmd_t cmd, logic [31:0] key);
		cmd_item_t it;
		it.cmd = cmd;
		it.key = key;
		cmd_queue.push_back(it);
		if (cmd == lpht_pkg::CMD_INSERT)
			placed_keys.push_back(key);
	endtask

	// accept, predict, check, watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			cycle_count++;
			if (s_tvalid && s_tready) begin
				expected_results.push_back(
					place_or_find(lpht_pkg::cmd_t'(s_tuser[0]), s_tdata));
				offer_taken = 1'b1;
			end
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("result %0d unexpected: status %0d slot %0d",
							results_seen, m_tuser, m_tdata[3:0]);
				end else begin
					want = expected_results.pop_front();
					if (m_tuser !== want.status || m_tdata[3:0] !== want.slot) begin
						errors++;
						if (errors <= MAX_REPORTS)
							$display("result %0d: expected status %0d slot %0d, got status %0d slot %0d",
								results_seen, want.status, want.slot, m_tuser, m_tdata[3:0]);
					end
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// command driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || offer_taken) begin
				offer_taken = 1'b0;
				if (cmd_queue.size() > 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
					next_item = cmd_queue.pop_front();
					s_tvalid <= 1'b1;
					s_tuser  <= next_item.cmd;
					s_tdata  <= next_item.key;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result receiver, with one long hold-off to back up the pipeline
	always @(negedge clk) begin
		if (arst_n) begin
			if (!hold_done && results_seen >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	initial begin
		int unsigned roll;
		logic [31:0] rnd;
		logic [31:0] base;
		for (int s = 0; s < SLOTS; s++)
			slot_taken[s] = 1'b0;

		// home slots, wrap past the last slot, duplicates, early and late misses
		add_item(lpht_pkg::CMD_INSERT, 32'h0000_0000);
		add_item(lpht_pkg::CMD_INSERT, 32'hFFFF_FFFF);
		add_item(lpht_pkg::CMD_INSERT, 32'h0000_001F);
		add_item(lpht_pkg::CMD_INSERT, 32'hFFFF_FFFF);
		add_item(lpht_pkg::CMD_SEARCH, 32'hFFFF_FFFF);
		add_item(lpht_pkg::CMD_SEARCH, 32'h0000_001F);
		add_item(lpht_pkg::CMD_SEARCH, 32'h0000_002F);
		add_item(lpht_pkg::CMD_SEARCH, 32'h0000_0005);
		add_item(lpht_pkg::CMD_SEARCH, 32'h0000_0000);
		add_item(lpht_pkg::CMD_SEARCH, 32'h8000_0000);
		add_item(lpht_pkg::CMD_INSERT, 32'h8000_0000);
		add_item(lpht_pkg::CMD_SEARCH, 32'h8000_0000);
		add_item(lpht_pkg::CMD_INSERT, 32'hAAAA_AAAA);
		add_item(lpht_pkg::CMD_INSERT, 32'h5555_5555);
		add_item(lpht_pkg::CMD_SEARCH, 32'h5555_5555);
		add_item(lpht_pkg::CMD_SEARCH, 32'hAAAA_AAAA);
		add_item(lpht_pkg::CMD_SEARCH, 32'h7FFF_FFFF);

		// inserts stay rare so the table fills slowly, then mostly overflow
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			roll = $urandom_range(0, 99);
			rnd = $urandom();
			if (roll < ((i < SLOW_FILL_ITEMS) ? 1 : 4)) begin
				if ($urandom_range(0, 99) < 30)
					add_item(lpht_pkg::CMD_INSERT,
						placed_keys[$urandom_range(0, placed_keys.size() - 1)]);
				else
					add_item(lpht_pkg::CMD_INSERT, rnd);
			end else begin
				roll = $urandom_range(0, 99);
				base = placed_keys[$urandom_range(0, placed_keys.size() - 1)];
				if (roll < 45)
					add_item(lpht_pkg::CMD_SEARCH, base);
				else if (roll < 75)
					add_item(lpht_pkg::CMD_SEARCH, {rnd[31:4], base[3:0]});
				else
					add_item(lpht_pkg::CMD_SEARCH, rnd);
			end
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (cmd_queue.size() == 0 && !s_tvalid);
		wait (expected_results.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* linear_probe_hash_table.f */
src/lpht_pkg.sv
src/lpht_ram.sv
src/lpht_front.sv
src/lpht_queue.sv
src/lpht_back.sv
src/linear_probe_hash_table.sv
src/lpht_checker.sv
bench/tb_linear_probe_hash_table.sv
